[rtl/multi_chain_ring_store_core_defines.svh]
// Assertion helpers shared by the ring store modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef MULTI_CHAIN_RING_STORE_CORE_DEFINES_SVH
`define MULTI_CHAIN_RING_STORE_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define MCRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define MCRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mcrs_pkg.sv]
package mcrs_pkg;

  // Default sizing
  localparam int unsigned MaxChainsDef = 8;
  localparam int unsigned MaxElemsDef  = 64;
  localparam int unsigned EntryBitsDef = 32;

  // Register reset values
  localparam int unsigned ElemsRstVal  = 20;
  localparam int unsigned ChainsRstVal = 1;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ELEMS  = 2'd0,
    CFG_CHAINS = 2'd1
  } mcrs_cfg_idx_e;

  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_CLEAR_ALL = 3'd3,
    OP_UPDATE    = 3'd4,
    OP_READ      = 3'd5,
    OP_COUNT     = 3'd6
  } mcrs_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAIN = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_RANGE     = 2'd3
  } mcrs_status_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_CALC = 2'd1,
    BK_ACC  = 2'd2
  } mcrs_state_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  chain_index;
    logic [5:0]  element_index;
    logic [31:0] entry_data;
  } mcrs_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [6:0]  element_count;
    logic [1:0]  status;
  } mcrs_out_t;

  // Classified command handed from front to back
  typedef struct packed {
    mcrs_op_e    kind;
    logic        bad_chain;
    logic [2:0]  chain;
    logic [5:0]  elem;
    logic [31:0] data;
  } mcrs_cmd_t;

endpackage

[rtl/mcrs_fifo.sv]
module mcrs_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mcrs_pkg::mcrs_cmd_t push_data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output mcrs_pkg::mcrs_cmd_t pop_data_o
);
  import mcrs_pkg::*;

  mcrs_cmd_t   entry_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  fill_q;
  logic        do_push, do_pop;

  assign do_push    = push_i && (fill_q != 2'd2);
  assign do_pop     = pop_i && (fill_q != 2'd0);
  assign valid_o    = (fill_q != 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // Store incoming commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

[rtl/mcrs_front.sv]
`include "multi_chain_ring_store_core_defines.svh"

module mcrs_front #(
  parameter int unsigned MAX_CHAINS = mcrs_pkg::MaxChainsDef,
  parameter int unsigned MAX_ELEMS  = mcrs_pkg::MaxElemsDef,
  localparam int unsigned CNT_W = $clog2(MAX_ELEMS + 1),
  localparam int unsigned NCH_W = $clog2(MAX_CHAINS + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  mcrs_pkg::mcrs_in_t              item_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mcrs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mcrs_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            res_valid_i,
  output logic                            push_o,
  output mcrs_pkg::mcrs_cmd_t             cmd_o,
  output logic [CNT_W-1:0]                cap_o,
  output logic                            cfg_clear_o
);
  import mcrs_pkg::*;

  localparam int unsigned CapRst = (ElemsRstVal > MAX_ELEMS) ? MAX_ELEMS : ElemsRstVal;
  localparam int unsigned NchRst = (ChainsRstVal > MAX_CHAINS) ? MAX_CHAINS : ChainsRstVal;

  logic [CNT_W-1:0] cap_q, cap_d;
  logic [NCH_W-1:0] nch_q, nch_d;
  logic             busy_q;
  logic             accept, cfg_wr;
  logic [3:0]       nch_raw;

  // Take register writes only while no item is in flight or being taken
  assign accept      = start && !busy_q;
  assign busy        = busy_q;
  assign cfg_ready_o = !busy_q && !start;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_clear_o = cfg_wr && ((cfg_index_i == CFG_ELEMS) || (cfg_index_i == CFG_CHAINS));
  assign cap_o       = cap_q;
  assign nch_raw     = cfg_data_i[3:0];

  // Clamp register writes into the supported range
  always_comb begin
    cap_d = cap_q;
    nch_d = nch_q;
    if (cfg_wr && (cfg_index_i == CFG_ELEMS)) begin
      if (cfg_data_i == '0) begin
        cap_d = CNT_W'(1);
      end else if (32'(cfg_data_i) > MAX_ELEMS) begin
        cap_d = CNT_W'(MAX_ELEMS);
      end else begin
        cap_d = CNT_W'(cfg_data_i);
      end
    end
    if (cfg_wr && (cfg_index_i == CFG_CHAINS)) begin
      if (nch_raw == '0) begin
        nch_d = NCH_W'(1);
      end else if (32'(nch_raw) > MAX_CHAINS) begin
        nch_d = NCH_W'(MAX_CHAINS);
      end else begin
        nch_d = NCH_W'(nch_raw);
      end
    end
  end

  // Classify the incoming item
  always_comb begin
    cmd_o.chain     = item_i.chain_index;
    cmd_o.elem      = item_i.element_index;
    cmd_o.data      = item_i.entry_data;
    cmd_o.bad_chain = (32'(item_i.chain_index) >= 32'(nch_q));
    case (item_i.operation)
      OP_ADD:       cmd_o.kind = OP_ADD;
      OP_REMOVE:    cmd_o.kind = OP_REMOVE;
      OP_CLEAR:     cmd_o.kind = OP_CLEAR;
      OP_CLEAR_ALL: cmd_o.kind = OP_CLEAR_ALL;
      OP_UPDATE:    cmd_o.kind = OP_UPDATE;
      OP_READ:      cmd_o.kind = OP_READ;
      default:      cmd_o.kind = OP_COUNT;
    endcase
  end

  assign push_o = accept;

  // Hold configuration and the busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CNT_W'(CapRst);
      nch_q  <= NCH_W'(NchRst);
      busy_q <= 1'b0;
    end else begin
      cap_q <= cap_d;
      nch_q <= nch_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (res_valid_i) begin
        busy_q <= 1'b0;
      end
    end
  end

  `MCRS_ASSERT_NEXT(a_accept_busy, accept, busy_q, "busy not raised after accept")
  `MCRS_ASSERT_NEXT(a_busy_holds, busy_q && !res_valid_i, busy_q, "busy dropped without result")
  `MCRS_ASSERT_NOW(a_result_owned, res_valid_i, busy_q, "result without an item in flight")

endmodule

[rtl/mcrs_back.sv]
`include "multi_chain_ring_store_core_defines.svh"

module mcrs_back #(
  parameter int unsigned MAX_CHAINS = mcrs_pkg::MaxChainsDef,
  parameter int unsigned MAX_ELEMS  = mcrs_pkg::MaxElemsDef,
  parameter int unsigned ENTRY_BITS = mcrs_pkg::EntryBitsDef,
  localparam int unsigned CNT_W = $clog2(MAX_ELEMS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  mcrs_pkg::mcrs_cmd_t   q_cmd_i,
  output logic                  pop_o,
  input  logic [CNT_W-1:0]      cap_i,
  input  logic                  cfg_clear_i,
  output logic                  res_valid_o,
  output mcrs_pkg::mcrs_out_t   res_o
);
  import mcrs_pkg::*;

  localparam int unsigned SLOT_W  = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int unsigned CIDX_W  = (MAX_CHAINS > 1) ? $clog2(MAX_CHAINS) : 1;
  localparam int unsigned DEPTH   = MAX_CHAINS * MAX_ELEMS;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned STORE_W = (ENTRY_BITS < 32) ? ENTRY_BITS : 32;
  localparam int unsigned SUM_W   = ((SLOT_W > 6) ? SLOT_W : 6) + 1;
  localparam int unsigned PROD_W  = CIDX_W + CNT_W;

  mcrs_state_e       state_q, state_d;
  logic              calc_en, acc_en;
  mcrs_cmd_t         cmd_q;

  logic [SLOT_W-1:0] head_q [MAX_CHAINS];
  logic [SLOT_W-1:0] tail_q [MAX_CHAINS];
  logic [SLOT_W-1:0] head_d [MAX_CHAINS];
  logic [SLOT_W-1:0] tail_d [MAX_CHAINS];
  logic [MAX_CHAINS-1:0] empty_q, empty_d;

  logic [CIDX_W-1:0] cidx;
  logic [SLOT_W-1:0] h, t, h_back, t_back, cap_m1;
  logic              e;
  logic [CNT_W-1:0]  cnt;
  logic [SUM_W-1:0]  sum, sum_slot;

  logic [SLOT_W-1:0] slot_q, slot_d;
  mcrs_status_e      status_q, status_d;
  logic              wr_q, wr_d, rd_ok_q, rd_ok_d;

  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] addr;
  logic [STORE_W-1:0] mem [DEPTH];
  logic [STORE_W-1:0] rd_q;

  logic              res_valid_q, res_rd_ok_q;
  logic [CNT_W-1:0]  res_count_q, cnt_fin;
  mcrs_status_e      res_status_q;

  // Next state
  always_comb begin
    case (state_q)
      BK_IDLE: state_d = q_valid_i ? BK_CALC : BK_IDLE;
      BK_CALC: state_d = BK_ACC;
      BK_ACC:  state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop_o   = 1'b0;
    calc_en = 1'b0;
    acc_en  = 1'b0;
    case (state_q)
      BK_IDLE: pop_o   = q_valid_i;
      BK_CALC: calc_en = 1'b1;
      BK_ACC:  acc_en  = 1'b1;
      default: pop_o   = 1'b0;
    endcase
  end

  // Look up the target chain
  assign cidx   = CIDX_W'(cmd_q.chain);
  assign h      = head_q[cidx];
  assign t      = tail_q[cidx];
  assign e      = empty_q[cidx];
  assign cap_m1 = SLOT_W'(cap_i - CNT_W'(1));
  assign h_back = (h == '0) ? cap_m1 : h - SLOT_W'(1);
  assign t_back = (t == '0) ? cap_m1 : t - SLOT_W'(1);

  // Entry count of the target chain
  always_comb begin
    if (e) begin
      cnt = '0;
    end else if (t >= h) begin
      cnt = CNT_W'(t) - CNT_W'(h) + CNT_W'(1);
    end else begin
      cnt = CNT_W'(t) + cap_i + CNT_W'(1) - CNT_W'(h);
    end
  end

  // Wrap the offset from the head into the ring
  assign sum      = SUM_W'(h) + SUM_W'(cmd_q.elem);
  assign sum_slot = (sum >= SUM_W'(cap_i)) ? sum - SUM_W'(cap_i) : sum;

  // Update pointers and decide the access
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    empty_d  = empty_q;
    slot_d   = slot_q;
    status_d = ST_OK;
    wr_d     = 1'b0;
    rd_ok_d  = 1'b0;
    if (cfg_clear_i || (calc_en && (cmd_q.kind == OP_CLEAR_ALL))) begin
      for (int i = 0; i < MAX_CHAINS; i++) begin
        head_d[i] = '0;
        tail_d[i] = '0;
      end
      empty_d = '1;
    end else if (calc_en) begin
      if (cmd_q.bad_chain) begin
        status_d = ST_BAD_CHAIN;
      end else begin
        case (cmd_q.kind)
          OP_ADD: begin
            wr_d = 1'b1;
            if (e) begin
              head_d[cidx]  = cap_m1;
              tail_d[cidx]  = cap_m1;
              empty_d[cidx] = 1'b0;
              slot_d        = cap_m1;
            end else begin
              head_d[cidx] = h_back;
              slot_d       = h_back;
              if (h_back == t) tail_d[cidx] = t_back;
            end
          end
          OP_REMOVE: begin
            if (e) begin
              status_d = ST_EMPTY;
            end else if (t == h) begin
              head_d[cidx]  = '0;
              tail_d[cidx]  = '0;
              empty_d[cidx] = 1'b1;
            end else begin
              tail_d[cidx] = t_back;
            end
          end
          OP_CLEAR: begin
            head_d[cidx]  = '0;
            tail_d[cidx]  = '0;
            empty_d[cidx] = 1'b1;
          end
          OP_UPDATE, OP_READ: begin
            if (e) begin
              status_d = ST_EMPTY;
            end else if (32'(cmd_q.elem) >= 32'(cnt)) begin
              status_d = ST_RANGE;
            end else begin
              slot_d  = SLOT_W'(sum_slot);
              wr_d    = (cmd_q.kind == OP_UPDATE);
              rd_ok_d = (cmd_q.kind == OP_READ);
            end
          end
          default: status_d = ST_OK;
        endcase
      end
    end
  end

  // Count after the operation
  assign cnt_fin = ((cmd_q.kind == OP_CLEAR_ALL) || cmd_q.bad_chain) ? '0 : cnt;

  // Element address inside the chain's slice
  assign prod = PROD_W'(cidx) * PROD_W'(cap_i);
  assign addr = ADDR_W'(prod + PROD_W'(slot_q));

  // Element memory
  always_ff @(posedge clk_i) begin
    if (acc_en) begin
      if (wr_q) mem[addr] <= cmd_q.data[STORE_W-1:0];
      rd_q <= mem[addr];
    end
  end

  // Capture the popped command and the access decision
  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= q_cmd_i;
    if (calc_en) slot_q <= slot_d;
    if (acc_en) res_count_q <= cnt_fin;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      empty_q      <= '1;
      status_q     <= ST_OK;
      wr_q         <= 1'b0;
      rd_ok_q      <= 1'b0;
      res_valid_q  <= 1'b0;
      res_rd_ok_q  <= 1'b0;
      res_status_q <= ST_OK;
      for (int i = 0; i < MAX_CHAINS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      empty_q     <= empty_d;
      res_valid_q <= acc_en;
      if (calc_en) begin
        status_q <= status_d;
        wr_q     <= wr_d;
        rd_ok_q  <= rd_ok_d;
      end
      if (acc_en) begin
        res_rd_ok_q  <= rd_ok_q;
        res_status_q <= status_q;
      end
    end
  end

  assign res_valid_o         = res_valid_q;
  assign res_o.read_data     = res_rd_ok_q ? 32'(rd_q) : '0;
  assign res_o.element_count = 7'(res_count_q);
  assign res_o.status        = res_status_q;

  `MCRS_ASSERT_NOW(a_res_after_acc, res_valid_q, $past(state_q == BK_ACC), "result not from access step")
  `MCRS_ASSERT_NOW(a_bad_zero, res_valid_q && (res_status_q == ST_BAD_CHAIN), res_count_q == '0, "bad chain with nonzero count")
  `MCRS_ASSERT_NOW(a_ptr_range, (state_q == BK_ACC) && !e, (32'(h) < 32'(cap_i)) && (32'(t) < 32'(cap_i)), "pointer beyond capacity")

endmodule

[rtl/multi_chain_ring_store_core.sv]
// Ring store of up to MAX_CHAINS independent chains in one element memory.
// An item is taken when start is high and busy is low; busy then stays high
// until its single result has been shown. Each item passes in turn through
// the command queue, a step that reads and updates the chain's head and
// tail pointers, and the registered memory access; its result is then shown
// on result_o, marked by result_valid_o for exactly one cycle, after which
// busy falls and the next item can be presented. The receiver cannot stall,
// so every result must be captured in the cycle it is shown. Configuration
// writes are taken only while busy and start are both low, and writes to
// the element or chain count register empty every chain.
module multi_chain_ring_store_core #(
  parameter int unsigned MAX_CHAINS = mcrs_pkg::MaxChainsDef,
  parameter int unsigned MAX_ELEMS  = mcrs_pkg::MaxElemsDef,
  parameter int unsigned ENTRY_BITS = mcrs_pkg::EntryBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  mcrs_pkg::mcrs_in_t            item_i,
  output logic                          result_valid_o,
  output mcrs_pkg::mcrs_out_t           result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mcrs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mcrs_pkg::CfgDataW-1:0] cfg_data_i
);
  import mcrs_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ELEMS + 1);

  logic             push, pop, q_valid, cfg_clear, res_valid;
  mcrs_cmd_t        push_cmd, q_cmd;
  logic [CNT_W-1:0] cap;

  mcrs_front #(
    .MAX_CHAINS (MAX_CHAINS),
    .MAX_ELEMS  (MAX_ELEMS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_i (res_valid),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .cap_o       (cap),
    .cfg_clear_o (cfg_clear)
  );

  mcrs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_cmd)
  );

  mcrs_back #(
    .MAX_CHAINS (MAX_CHAINS),
    .MAX_ELEMS  (MAX_ELEMS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .pop_o       (pop),
    .cap_i       (cap),
    .cfg_clear_i (cfg_clear),
    .res_valid_o (res_valid),
    .res_o       (result_o)
  );

  assign result_valid_o = res_valid;

endmodule

[test/tb_multi_chain_ring_store_core.sv]
module tb_multi_chain_ring_store_core;
  import mcrs_pkg::*;

  localparam int SettleCycles = 8;
  localparam int IdleLimit    = 2000;
  localparam int MaxReports   = 200;
  localparam int StoreDepth   = MaxChainsDef * MaxElemsDef;
  // Operation code with no function of its own; the block treats it as count
  localparam logic [2:0] OP_SPARE = 3'd7;
  // Register index with no register behind it
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd2;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  mcrs_in_t            item_i      = '0;
  logic                result_valid_o;
  mcrs_out_t           result_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  multi_chain_ring_store_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Commands waiting to be sent and results owed by the block
  mcrs_in_t  cmd_queue[$];
  mcrs_out_t due_results[$];

  // Shadow copy of the chain pointers, the element memory and the registers
  logic [6:0]  elems_reg;
  logic [3:0]  chains_reg;
  logic [5:0]  head_at  [MaxChainsDef];
  logic [5:0]  tail_at  [MaxChainsDef];
  logic        ring_empty [MaxChainsDef];
  logic [31:0] ring_mem [StoreDepth];

  int mismatches;
  int items_sent;
  int results_seen;
  int cfg_writes;
  int settings_run;
  int status_seen [4];
  int burst_left;
  int gap_left;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int ring_cap();
    int e;
    e = elems_reg;
    if (e < 1) e = 1;
    if (e > int'(MaxElemsDef)) e = MaxElemsDef;
    return e;
  endfunction

  function automatic int chain_limit();
    int c;
    c = chains_reg;
    if (c < 1) c = 1;
    if (c > int'(MaxChainsDef)) c = MaxChainsDef;
    return c;
  endfunction

  function automatic void empty_all();
    for (int c = 0; c < int'(MaxChainsDef); c++) begin
      head_at[c]    = '0;
      tail_at[c]    = '0;
      ring_empty[c] = 1'b1;
    end
  endfunction

  function automatic int fill_of(int c);
    if (ring_empty[c]) return 0;
    if (tail_at[c] >= head_at[c]) return int'(tail_at[c]) - int'(head_at[c]) + 1;
    return int'(tail_at[c]) + ring_cap() + 1 - int'(head_at[c]);
  endfunction

  function automatic logic [5:0] step_back(logic [5:0] s);
    return (s == 0) ? 6'(ring_cap() - 1) : s - 6'd1;
  endfunction

  // Apply one command to the shadow chains and return the answer it earns
  function automatic mcrs_out_t apply_ring_op(mcrs_in_t cmd);
    mcrs_out_t r;
    int        e;
    int        c;
    int        n;
    int        slot;
    r = '0;
    e = ring_cap();
    c = cmd.chain_index;
    if (cmd.operation == OP_CLEAR_ALL) begin
      empty_all();
      return r;
    end
    if (c >= chain_limit()) begin
      r.status = ST_BAD_CHAIN;
      return r;
    end
    n = fill_of(c);
    case (cmd.operation)
      OP_ADD: begin
        if (ring_empty[c]) begin
          tail_at[c]    = 6'(e - 1);
          head_at[c]    = 6'(e - 1);
          ring_empty[c] = 1'b0;
        end else begin
          head_at[c] = step_back(head_at[c]);
          if (head_at[c] == tail_at[c]) tail_at[c] = step_back(tail_at[c]);
        end
        ring_mem[c * e + int'(head_at[c])] = cmd.entry_data;
      end
      OP_REMOVE: begin
        if (ring_empty[c]) begin
          r.status = ST_EMPTY;
        end else if (tail_at[c] == head_at[c]) begin
          head_at[c]    = '0;
          tail_at[c]    = '0;
          ring_empty[c] = 1'b1;
        end else begin
          tail_at[c] = step_back(tail_at[c]);
        end
      end
      OP_CLEAR: begin
        head_at[c]    = '0;
        tail_at[c]    = '0;
        ring_empty[c] = 1'b1;
      end
      OP_UPDATE, OP_READ: begin
        if (ring_empty[c]) begin
          r.status = ST_EMPTY;
        end else if (int'(cmd.element_index) >= n) begin
          r.status = ST_RANGE;
        end else begin
          slot = (int'(head_at[c]) + int'(cmd.element_index)) % e;
          if (cmd.operation == OP_UPDATE) ring_mem[c * e + slot] = cmd.entry_data;
          else r.read_data = ring_mem[c * e + slot];
        end
      end
      default: ;
    endcase
    r.element_count = 7'(fill_of(c));
    return r;
  endfunction

  function automatic void push_cmd(logic [2:0] op, logic [2:0] ch, logic [5:0] ei,
                                   logic [31:0] d);
    mcrs_in_t cmd;
    cmd.operation     = op;
    cmd.chain_index   = ch;
    cmd.element_index = ei;
    cmd.entry_data    = d;
    cmd_queue.push_back(cmd);
  endfunction

  // Fill the send queue with commands aimed mostly at chains in use
  task automatic queue_random(int n, int add_pct, bit wipe);
    logic [2:0] op;
    int         pick;
    int         e;
    int         nch;
    logic [5:0] ei;
    logic [2:0] ch;
    e   = ring_cap();
    nch = chain_limit();
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < add_pct) begin
        op = OP_ADD;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35)      op = OP_READ;
        else if (pick < 55) op = OP_UPDATE;
        else if (pick < 75) op = OP_REMOVE;
        else if (pick < 88) op = OP_COUNT;
        else if (pick < 93) op = OP_CLEAR;
        else if (pick < 97) op = OP_SPARE;
        else                op = OP_CLEAR_ALL;
        if (!wipe && (op == OP_CLEAR || op == OP_CLEAR_ALL)) op = OP_COUNT;
      end
      ch = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                       : 3'($urandom_range(0, nch - 1));
      pick = $urandom_range(0, 9);
      if (pick < 5)      ei = 6'($urandom_range(0, 3));
      else if (pick < 8) ei = 6'($urandom_range(0, e - 1));
      else               ei = 6'($urandom_range(0, 63));
      push_cmd(op, ch, ei, $urandom());
    end
  endtask

  // Hold until every command is sent and answered, then let the pipeline settle
  task automatic drain();
    while (cmd_queue.size() != 0 || due_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ELEMS: begin
        elems_reg = val;
        empty_all();
      end
      CFG_CHAINS: begin
        chains_reg = val[3:0];
        empty_all();
      end
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Program both sizes, then send two batches with a full pause between them
  task automatic run_setting(logic [6:0] elems, logic [6:0] chains, int n, int add_pct,
                             bit wipe);
    write_reg(CFG_ELEMS, elems);
    write_reg(CFG_CHAINS, chains);
    settings_run++;
    queue_random(n / 2, add_pct, wipe);
    drain();
    queue_random(n - n / 2, add_pct, wipe);
    drain();
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // Present queued commands in bursts; retire each one on its transfer
  always @(posedge clk_i or negedge rst_ni) begin : drive_cmds
    logic taken;
    if (!rst_ni) begin
      start      <= 1'b0;
      item_i     <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        due_results.push_back(apply_ring_op(item_i));
        void'(cmd_queue.pop_front());
        items_sent++;
      end
      if (start && !taken) begin
        // hold the command until the block takes it
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        start  <= 1'b1;
        item_i <= cmd_queue[0];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Compare each shown result with the oldest one owed
  always @(posedge clk_i) begin : check_results
    mcrs_out_t want;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (!$isunknown(result_o.status)) status_seen[result_o.status]++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: result with none expected, got %h", $time, result_o);
      end else begin
        want = due_results.pop_front();
        check_field("read_data", want.read_data, result_o.read_data);
        check_field("element_count", 32'(want.element_count), 32'(result_o.element_count));
        check_field("status", 32'(want.status), 32'(result_o.status));
      end
    end
  end

  // Stop the run when no transfer of any kind happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: watchdog, no transfer for %0d cycles", $time, IdleLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    elems_reg  = 7'(ElemsRstVal);
    chains_reg = 4'(ChainsRstVal);
    empty_all();
    for (int a = 0; a < StoreDepth; a++) ring_mem[a] = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset sizes: empty refusals, fill, indexed access, bad chains, clears
    push_cmd(OP_COUNT,     3'd0, 6'd0,  32'h0);
    push_cmd(OP_REMOVE,    3'd0, 6'd0,  32'h0);
    push_cmd(OP_READ,      3'd0, 6'd0,  32'h0);
    push_cmd(OP_UPDATE,    3'd0, 6'd0,  32'h1111_1111);
    push_cmd(OP_ADD,       3'd0, 6'd0,  32'h0000_0000);
    push_cmd(OP_ADD,       3'd0, 6'd63, 32'hFFFF_FFFF);
    push_cmd(OP_ADD,       3'd0, 6'd0,  32'hA5A5_5A5A);
    push_cmd(OP_READ,      3'd0, 6'd0,  32'h0);
    push_cmd(OP_READ,      3'd0, 6'd2,  32'h0);
    push_cmd(OP_READ,      3'd0, 6'd3,  32'h0);
    push_cmd(OP_UPDATE,    3'd0, 6'd63, 32'hDEAD_BEEF);
    push_cmd(OP_UPDATE,    3'd0, 6'd1,  32'h1234_5678);
    push_cmd(OP_READ,      3'd0, 6'd1,  32'h0);
    push_cmd(OP_ADD,       3'd1, 6'd0,  32'h5555_AAAA);
    push_cmd(OP_READ,      3'd7, 6'd0,  32'h0);
    push_cmd(OP_SPARE,     3'd0, 6'd0,  32'h0);
    push_cmd(OP_REMOVE,    3'd0, 6'd0,  32'h0);
    push_cmd(OP_CLEAR,     3'd0, 6'd0,  32'h0);
    push_cmd(OP_ADD,       3'd0, 6'd0,  32'h0F0F_F0F0);
    push_cmd(OP_CLEAR_ALL, 3'd5, 6'd21, 32'h7777_7777);
    drain();

    // Two-entry rings: overwrite of the oldest, then remove down to empty
    write_reg(CFG_ELEMS, 7'd2);
    write_reg(CFG_CHAINS, 7'd8);
    settings_run++;
    push_cmd(OP_ADD,    3'd3, 6'd0, 32'hC0DE_0001);
    push_cmd(OP_ADD,    3'd3, 6'd0, 32'hC0DE_0002);
    push_cmd(OP_ADD,    3'd3, 6'd0, 32'hC0DE_0003);
    push_cmd(OP_READ,   3'd3, 6'd0, 32'h0);
    push_cmd(OP_READ,   3'd3, 6'd1, 32'h0);
    push_cmd(OP_READ,   3'd3, 6'd2, 32'h0);
    push_cmd(OP_REMOVE, 3'd3, 6'd0, 32'h0);
    push_cmd(OP_REMOVE, 3'd3, 6'd0, 32'h0);
    push_cmd(OP_REMOVE, 3'd3, 6'd0, 32'h0);
    drain();
    queue_random(150, 45, 1'b1);
    drain();

    // Sweep sizes, including values the block must clamp
    run_setting(7'd0,   7'd8,   160, 45, 1'b1);
    run_setting(7'd127, 7'h7F,  160, 45, 1'b1);
    run_setting(7'd64,  7'd1,   260, 80, 1'b0);
    run_setting(7'd3,   7'd0,   160, 45, 1'b1);
    run_setting(7'd5,   7'h14,  160, 45, 1'b1);
    run_setting(7'd1,   7'd1,   120, 45, 1'b1);
    run_setting(7'd7,   7'd2,   160, 50, 1'b1);
    run_setting(7'd20,  7'd8,   160, 45, 1'b1);
    run_setting(7'd33,  7'd5,   160, 55, 1'b0);

    // A write to an unused index must leave the chains intact
    write_reg(CFG_SPARE, 7'h7F);
    queue_random(100, 45, 1'b1);
    drain();

    $display("covered %0d commands over %0d size settings with %0d register writes",
             items_sent, settings_run, cfg_writes);
    $display("answers: %0d ok, %0d bad chain, %0d empty, %0d beyond count; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_BAD_CHAIN], status_seen[ST_EMPTY],
             status_seen[ST_RANGE], mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/mcrs_pkg.sv
rtl/mcrs_fifo.sv
rtl/mcrs_front.sv
rtl/mcrs_back.sv
rtl/multi_chain_ring_store_core.sv
test/tb_multi_chain_ring_store_core.sv
